// ----- src/forward_value_location_tracker_unit_macros.svh -----
// Assertion helpers shared by the tracker RTL.
`ifndef FORWARD_VALUE_LOCATION_TRACKER_UNIT_MACROS_SVH
`define FORWARD_VALUE_LOCATION_TRACKER_UNIT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define FVLT_AST_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define FVLT_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- src/fvlt_pkg.sv -----
package fvlt_pkg;

  localparam int LOC_W = 18;

  typedef logic [LOC_W-1:0] loc_t;
  typedef logic [1:0]       kind_t;
  typedef logic [3:0]       cmd_t;
  typedef logic [1:0]       opcls_t;

  // Location kinds
  localparam kind_t KIND_REG   = 2'd0;
  localparam kind_t KIND_STK64 = 2'd1;
  localparam kind_t KIND_STK8  = 2'd2;

  // Instruction commands
  localparam cmd_t CMD_OTHER     = 4'd0;
  localparam cmd_t CMD_BEGIN     = 4'd1;
  localparam cmd_t CMD_FSTART    = 4'd2;
  localparam cmd_t CMD_STRX      = 4'd3;
  localparam cmd_t CMD_LDRX      = 4'd4;
  localparam cmd_t CMD_STRW      = 4'd5;
  localparam cmd_t CMD_LDRW      = 4'd6;
  localparam cmd_t CMD_MOVX      = 4'd7;
  localparam cmd_t CMD_MOVW      = 4'd8;
  localparam cmd_t CMD_STRB_IMM  = 4'd9;
  localparam cmd_t CMD_STRB_POST = 4'd10;
  localparam cmd_t CMD_STRB_PRE  = 4'd11;

  // Operation classes after decode
  localparam opcls_t OP_NONE   = 2'd0;
  localparam opcls_t OP_BEGIN  = 2'd1;
  localparam opcls_t OP_FSTART = 2'd2;
  localparam opcls_t OP_TRACK  = 2'd3;

  localparam logic [4:0]  SP_REG    = 5'd31;
  localparam logic [15:0] STRB_MASK = 16'h01FF;

  typedef struct packed {
    opcls_t cls;
    logic   query_en;
    loc_t   qkey;
    loc_t   tkey;
    logic   add_ok;
    logic   del_ok;
    logic   anchor_hit;
  } op_t;

  function automatic loc_t make_loc(kind_t kind, logic [15:0] val);
    return {kind, val};
  endfunction

endpackage

// ----- src/fvlt_ram.sv -----
module fvlt_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/fvlt_decode.sv -----
module fvlt_decode
  import fvlt_pkg::*;
(
  input  logic [3:0]  cmd,
  input  logic [4:0]  rt,
  input  logic [4:0]  rn,
  input  logic [4:0]  rm,
  input  logic [15:0] imm,
  input  logic [30:0] offset,
  input  logic [30:0] anchor,
  input  logic        set_empty,
  input  logic        stopped,
  output op_t         op
);

  logic [15:0] bimm;
  logic        sp_base;

  assign bimm    = (cmd == CMD_STRB_IMM) ? imm : (imm & STRB_MASK);
  assign sp_base = (rn == SP_REG);

  // Map one instruction onto a query key, a target key and the follow-up action
  always_comb begin
    op            = '0;
    op.cls        = OP_NONE;
    op.qkey       = make_loc(KIND_REG, {11'd0, rt});
    op.tkey       = make_loc(KIND_REG, {11'd0, rt});
    if (cmd == CMD_BEGIN) begin
      op.cls = OP_BEGIN;
    end else if (!stopped) begin
      case (cmd)
        CMD_FSTART: begin
          op.cls = OP_FSTART;
        end
        CMD_STRX, CMD_STRW: begin
          if (sp_base) begin
            op.cls      = OP_TRACK;
            op.query_en = 1'b1;
            op.qkey     = make_loc(KIND_REG, {11'd0, rt});
            op.tkey     = make_loc(KIND_STK64, imm);
            op.add_ok   = 1'b1;
            op.del_ok   = 1'b1;
          end
        end
        CMD_LDRX, CMD_LDRW: begin
          if (sp_base) begin
            op.cls      = OP_TRACK;
            op.query_en = 1'b1;
            op.qkey     = make_loc(KIND_STK64, imm);
            op.tkey     = make_loc(KIND_REG, {11'd0, rt});
            op.add_ok   = 1'b1;
            op.del_ok   = 1'b1;
          end
        end
        CMD_MOVX, CMD_MOVW: begin
          // a move into register 31 only overwrites it
          op.cls      = OP_TRACK;
          op.query_en = (rt != SP_REG);
          op.qkey     = make_loc(KIND_REG, {11'd0, rm});
          op.tkey     = make_loc(KIND_REG, {11'd0, rt});
          op.add_ok   = 1'b1;
          op.del_ok   = 1'b1;
        end
        CMD_STRB_IMM, CMD_STRB_POST, CMD_STRB_PRE: begin
          op.cls        = OP_TRACK;
          op.query_en   = 1'b1;
          op.qkey       = make_loc(KIND_REG, {11'd0, rt});
          op.tkey       = make_loc(KIND_STK8, bimm);
          op.add_ok     = sp_base;
          op.del_ok     = sp_base;
          op.anchor_hit = set_empty && (offset > anchor);
        end
        default: begin
          op.cls = OP_NONE;
        end
      endcase
    end
  end

endmodule

// ----- src/forward_value_location_tracker_unit.sv -----
// Forward value-location tracker.
// Input channel (in_valid/in_stall): one decoded instruction per transfer,
// fields in_cmd, in_rt, in_rn, in_rm, in_imm, in_offset.
// Result channel (out_valid/out_stall): one result per instruction with
// out_sink, out_boundary_reached, out_set_count and out_dropped_full.
// Config: cfg_we with cfg_wdata writes the anchor offset; write it only idle.
// The tracked set lives in a single-port-read location memory; each lookup
// walks entries 0..N-1 at one entry per cycle, N being the set size.
// Items that need no lookup (begin, function start, untracked commands,
// anything while stopped) go from idle straight to the finish state; a
// tracked instruction does the query lookup, then the target lookup when it
// adds or removes, and a removal that hits reads and moves the last entry.
// One item is in flight at a time; in_stall is high while it is worked on.
// The result sits in an output register, so the next item is taken while a
// result waits; a stalled result holds the following item in its finish state.
// Reset: set empty, tracking stopped until a begin, anchor cleared. The
// memory is not cleared; only entries below the count are ever read.
`include "forward_value_location_tracker_unit_macros.svh"

module forward_value_location_tracker_unit
  import fvlt_pkg::*;
#(
  parameter int MAX_LOCATIONS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [30:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_cmd,
  input  logic [4:0]  in_rt,
  input  logic [4:0]  in_rn,
  input  logic [4:0]  in_rm,
  input  logic [15:0] in_imm,
  input  logic [30:0] in_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_sink,
  output logic        out_boundary_reached,
  output logic [8:0]  out_set_count,
  output logic        out_dropped_full
);

  localparam int AW = $clog2(MAX_LOCATIONS);
  localparam int CW = $clog2(MAX_LOCATIONS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_QSCAN = 3'd1;
  localparam logic [2:0] S_TSCAN = 3'd2;
  localparam logic [2:0] S_DRQ   = 3'd3;
  localparam logic [2:0] S_DWR   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          stopped_r, stopped_nxt;
  logic [30:0]   anchor_r;
  logic          pend_r, pend_nxt;
  logic          out_valid_r, out_valid_nxt;

  op_t           op_r, op_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] pidx_r, pidx_nxt;
  logic [AW-1:0] hit_idx_r, hit_idx_nxt;
  logic          add_mode_r, add_mode_nxt;
  logic          res_sink_r, res_sink_nxt;
  logic          res_boundary_r, res_boundary_nxt;
  logic          res_dropped_r, res_dropped_nxt;
  logic          out_sink_r, out_sink_nxt;
  logic          out_boundary_r, out_boundary_nxt;
  logic [8:0]    out_count_r, out_count_nxt;
  logic          out_dropped_r, out_dropped_nxt;

  op_t           dec_op;
  loc_t          key;
  logic [CW-1:0] lim;
  logic [CW-1:0] cnt_m1;
  logic [31:0]   cnt_w;
  logic          issue;
  logic          hit_now;
  logic          scan_miss;
  logic          qhit;
  logic          slot_free;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  loc_t          ram_wdata;
  logic [AW-1:0] ram_raddr;
  loc_t          ram_rdata;

  fvlt_decode u_decode (
    .cmd       (in_cmd),
    .rt        (in_rt),
    .rn        (in_rn),
    .rm        (in_rm),
    .imm       (in_imm),
    .offset    (in_offset),
    .anchor    (anchor_r),
    .set_empty (count_r == '0),
    .stopped   (stopped_r),
    .op        (dec_op)
  );

  fvlt_ram #(
    .WIDTH (LOC_W),
    .DEPTH (MAX_LOCATIONS)
  ) u_loc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Scan helpers
  assign key       = (state_r == S_QSCAN) ? op_r.qkey : op_r.tkey;
  assign lim       = (state_r == S_QSCAN && !op_r.query_en) ? '0 : count_r;
  assign issue     = (idx_r < lim);
  assign hit_now   = pend_r && (ram_rdata == key);
  assign scan_miss = !issue && !pend_r;
  assign cnt_m1    = count_r - CW'(1);
  assign cnt_w     = 32'(count_r);
  assign slot_free = !out_valid_r || !out_stall;

  // Sequencer: query lookup, target lookup, then add or remove
  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    stopped_nxt      = stopped_r;
    pend_nxt         = pend_r;
    out_valid_nxt    = out_valid_r;
    op_nxt           = op_r;
    idx_nxt          = idx_r;
    pidx_nxt         = pidx_r;
    hit_idx_nxt      = hit_idx_r;
    add_mode_nxt     = add_mode_r;
    res_sink_nxt     = res_sink_r;
    res_boundary_nxt = res_boundary_r;
    res_dropped_nxt  = res_dropped_r;
    out_sink_nxt     = out_sink_r;
    out_boundary_nxt = out_boundary_r;
    out_count_nxt    = out_count_r;
    out_dropped_nxt  = out_dropped_r;
    ram_we           = 1'b0;
    ram_waddr        = '0;
    ram_wdata        = op_r.tkey;
    ram_raddr        = idx_r[AW-1:0];
    qhit             = hit_now || op_r.anchor_hit;

    // drop the result once transferred
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt           = dec_op;
          res_sink_nxt     = 1'b0;
          res_boundary_nxt = 1'b0;
          res_dropped_nxt  = 1'b0;
          idx_nxt          = '0;
          pend_nxt         = 1'b0;
          case (dec_op.cls)
            OP_BEGIN: begin
              ram_we      = 1'b1;
              ram_waddr   = '0;
              ram_wdata   = dec_op.tkey;
              count_nxt   = CW'(1);
              stopped_nxt = 1'b0;
              state_nxt   = S_FIN;
            end
            OP_FSTART: begin
              stopped_nxt      = 1'b1;
              res_boundary_nxt = 1'b1;
              state_nxt        = S_FIN;
            end
            OP_TRACK: begin
              state_nxt = S_QSCAN;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_QSCAN, S_TSCAN: begin
        if (hit_now || scan_miss) begin
          pend_nxt = 1'b0;
          idx_nxt  = '0;
          if (state_r == S_QSCAN) begin
            res_sink_nxt = qhit;
            if (qhit && op_r.add_ok) begin
              add_mode_nxt = 1'b1;
              state_nxt    = S_TSCAN;
            end else if (!qhit && op_r.del_ok) begin
              add_mode_nxt = 1'b0;
              state_nxt    = S_TSCAN;
            end else begin
              state_nxt = S_FIN;
            end
          end else if (add_mode_r) begin
            state_nxt = S_FIN;
            if (!hit_now) begin
              if (count_r == CW'(MAX_LOCATIONS)) begin
                res_dropped_nxt = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_r[AW-1:0];
                count_nxt = count_r + CW'(1);
              end
            end
          end else if (hit_now) begin
            hit_idx_nxt = pidx_r;
            state_nxt   = S_DRQ;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          // advance the walk, one read per cycle
          pend_nxt = issue;
          pidx_nxt = idx_r[AW-1:0];
          if (issue) begin
            idx_nxt = idx_r + CW'(1);
          end
        end
      end
      S_DRQ: begin
        ram_raddr = cnt_m1[AW-1:0];
        state_nxt = S_DWR;
      end
      S_DWR: begin
        // move the last entry into the freed slot
        ram_we    = 1'b1;
        ram_waddr = hit_idx_r;
        ram_wdata = ram_rdata;
        count_nxt = cnt_m1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          out_valid_nxt    = 1'b1;
          out_sink_nxt     = res_sink_r;
          out_boundary_nxt = res_boundary_r;
          out_dropped_nxt  = res_dropped_r;
          out_count_nxt    = cnt_w[8:0];
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      stopped_r   <= 1'b1;
      anchor_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      stopped_r   <= stopped_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        anchor_r <= cfg_wdata;
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    op_r           <= op_nxt;
    idx_r          <= idx_nxt;
    pidx_r         <= pidx_nxt;
    hit_idx_r      <= hit_idx_nxt;
    add_mode_r     <= add_mode_nxt;
    res_sink_r     <= res_sink_nxt;
    res_boundary_r <= res_boundary_nxt;
    res_dropped_r  <= res_dropped_nxt;
    out_sink_r     <= out_sink_nxt;
    out_boundary_r <= out_boundary_nxt;
    out_count_r    <= out_count_nxt;
    out_dropped_r  <= out_dropped_nxt;
  end

  assign in_stall             = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_sink             = out_sink_r;
  assign out_boundary_reached = out_boundary_r;
  assign out_set_count        = out_count_r;
  assign out_dropped_full     = out_dropped_r;

  // Checks
  `FVLT_AST_NOW(a_count_bound, count_r <= CW'(MAX_LOCATIONS), "set count above capacity")
  `FVLT_AST_NOW(a_count_step, (count_r == $past(count_r)) || (count_r == $past(count_r) + CW'(1)) || (count_r == $past(count_r) - CW'(1)) || (count_r == CW'(1)), "set count jumped")
  `FVLT_AST_IMP(a_pend_in_set, pend_r, CW'(pidx_r) < count_r, "pending read beyond set")
  `FVLT_AST_IMP(a_drop_full, (state_r == S_FIN) && res_dropped_r, count_r == CW'(MAX_LOCATIONS), "drop flagged with room left")
  `FVLT_AST_IMP(a_bound_stop, (state_r == S_FIN) && res_boundary_r, stopped_r, "boundary without stop")

endmodule

// ----- tb/sv/tb.sv -----
module tb
  import fvlt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_LOC          = 256;
  localparam int unsigned RUN_LIMIT        = 2_000_000;
  localparam int unsigned TAIL_CYCLES      = 2 * MAX_LOC + 16;
  localparam int unsigned RANDOM_PER_PHASE = 90;

  // Command codes the block does not decode
  localparam cmd_t CMD_UNUSED_LO = 4'd12;
  localparam cmd_t CMD_UNUSED_HI = 4'd15;

  // Location: kind in the top two bits, register number or stack offset below
  typedef logic [17:0] place_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [4:0]  rt;
    logic [4:0]  rn;
    logic [4:0]  rm;
    logic [15:0] imm;
    logic [30:0] offset;
  } instr_t;

  typedef struct packed {
    logic       sink;
    logic       boundary;
    logic [8:0] count;
    logic       dropped;
  } outcome_t;

  // Tracked-set predictor and store of the outcomes still to come
  class location_board;
    place_t      places[MAX_LOC];
    int unsigned held;
    bit          halted;
    logic [30:0] anchor;
    outcome_t    expected_results[$];
    int unsigned mismatches;

    function new();
      held       = 0;
      halted     = 1'b1;
      anchor     = '0;
      mismatches = 0;
    endfunction

    function bit holds(place_t p);
      int unsigned i;
      for (i = 0; i < held; i++)
        if (places[i] == p) return 1'b1;
      return 1'b0;
    endfunction

    // Add a location; flag a drop when the set is already full
    function bit insert(place_t p);
      if (holds(p)) return 1'b0;
      if (held >= MAX_LOC) return 1'b1;
      places[held] = p;
      held++;
      return 1'b0;
    endfunction

    // Remove a location and move the last entry into its slot
    function void remove(place_t p);
      int unsigned i;
      for (i = 0; i < held; i++) begin
        if (places[i] == p) begin
          places[i] = places[held - 1];
          held--;
          return;
        end
      end
    endfunction

    // Advance the set by one accepted instruction and queue its outcome
    function void note_instr(instr_t it);
      outcome_t    res;
      logic [15:0] bimm;
      res = '0;
      if (it.cmd == CMD_BEGIN) begin
        held        = 0;
        res.dropped = insert({KIND_REG, 11'd0, it.rt});
        halted      = 1'b0;
      end else if (!halted) begin
        case (it.cmd)
          CMD_FSTART: begin
            halted       = 1'b1;
            res.boundary = 1'b1;
          end
          CMD_STRX, CMD_STRW: begin
            if (it.rn == SP_REG) begin
              if (holds({KIND_REG, 11'd0, it.rt})) begin
                res.sink    = 1'b1;
                res.dropped = insert({KIND_STK64, it.imm});
              end else begin
                remove({KIND_STK64, it.imm});
              end
            end
          end
          CMD_LDRX, CMD_LDRW: begin
            if (it.rn == SP_REG) begin
              if (holds({KIND_STK64, it.imm})) begin
                res.sink    = 1'b1;
                res.dropped = insert({KIND_REG, 11'd0, it.rt});
              end else begin
                remove({KIND_REG, 11'd0, it.rt});
              end
            end
          end
          CMD_MOVX, CMD_MOVW: begin
            if (holds({KIND_REG, 11'd0, it.rm}) && it.rt != SP_REG) begin
              res.sink    = 1'b1;
              res.dropped = insert({KIND_REG, 11'd0, it.rt});
            end else begin
              remove({KIND_REG, 11'd0, it.rt});
            end
          end
          CMD_STRB_IMM, CMD_STRB_POST, CMD_STRB_PRE: begin
            bimm = (it.cmd == CMD_STRB_IMM) ? it.imm : (it.imm & STRB_MASK);
            if (holds({KIND_REG, 11'd0, it.rt}) || (held == 0 && it.offset > anchor)) begin
              res.sink = 1'b1;
              if (it.rn == SP_REG) res.dropped = insert({KIND_STK8, bimm});
            end else if (it.rn == SP_REG) begin
              remove({KIND_STK8, bimm});
            end
          end
          default: ;
        endcase
      end
      res.count = 9'(held);
      expected_results.push_back(res);
    endfunction

    // Compare one result transfer with the oldest outcome
    function void check_result(outcome_t got);
      outcome_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: sink=%0b boundary=%0b count=%0d dropped=%0b",
                   got.sink, got.boundary, got.count, got.dropped);
        return;
      end
      want = expected_results.pop_front();
      if (got.sink !== want.sink || got.boundary !== want.boundary ||
          got.count !== want.count || got.dropped !== want.dropped) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: sink %0b/%0b boundary %0b/%0b count %0d/%0d dropped %0b/%0b",
                   want.sink, got.sink, want.boundary, got.boundary,
                   want.count, got.count, want.dropped, got.dropped);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n                = 1'b0;
  logic        cfg_we               = 1'b0;
  logic [30:0] cfg_wdata            = '0;
  logic        in_valid             = 1'b0;
  logic        in_stall;
  logic [3:0]  in_cmd               = '0;
  logic [4:0]  in_rt                = '0;
  logic [4:0]  in_rn                = '0;
  logic [4:0]  in_rm                = '0;
  logic [15:0] in_imm               = '0;
  logic [30:0] in_offset            = '0;
  logic        out_valid;
  logic        out_stall            = 1'b0;
  logic        out_sink;
  logic        out_boundary_reached;
  logic [8:0]  out_set_count;
  logic        out_dropped_full;

  location_board board = new();
  int unsigned   burst_left = 0;
  int unsigned   stall_run  = 0;
  int unsigned   stall_mode = 0;
  int unsigned   cycle_count = 0;

  forward_value_location_tracker_unit #(
    .MAX_LOCATIONS(MAX_LOC)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_rt               (in_rt),
    .in_rn               (in_rn),
    .in_rm               (in_rm),
    .in_imm              (in_imm),
    .in_offset           (in_offset),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_sink            (out_sink),
    .out_boundary_reached(out_boundary_reached),
    .out_set_count       (out_set_count),
    .out_dropped_full    (out_dropped_full)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: switch between free flow, light, heavy and near-constant stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_run  <= 0;
      stall_mode <= 0;
    end else begin
      if (stall_run == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_run  <= $urandom_range(1, 40);
      end else begin
        stall_run <= stall_run - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= $urandom_range(0, 1);
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(outcome_t'({out_sink, out_boundary_reached, out_set_count,
                                     out_dropped_full}));
  end

  // Hold one instruction until it transfers, then idle at most burst ends
  task automatic feed(input instr_t it);
    int unsigned gap;
    in_valid  <= 1'b1;
    in_cmd    <= it.cmd;
    in_rt     <= it.rt;
    in_rn     <= it.rn;
    in_rm     <= it.rm;
    in_imm    <= it.imm;
    in_offset <= it.offset;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_instr(it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Wait until every queued outcome has been checked, then a little longer
  task automatic drain(input int unsigned tail);
    in_valid <= 1'b0;
    while (board.expected_results.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_anchor(input logic [30:0] value);
    drain(4);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    board.anchor = value;
  endtask

  function automatic instr_t decoded(cmd_t cmd, logic [4:0] rt, logic [4:0] rn,
                                     logic [4:0] rm, logic [15:0] imm,
                                     logic [30:0] offset);
    instr_t it;
    it.cmd    = cmd;
    it.rt     = rt;
    it.rn     = rn;
    it.rm     = rm;
    it.imm    = imm;
    it.offset = offset;
    return it;
  endfunction

  // Mostly a handful of registers so that moves and spills hit the set
  function automatic logic [4:0] pick_reg();
    case ($urandom_range(0, 9))
      0:       return SP_REG;
      1:       return 5'($urandom);
      default: return 5'($urandom_range(0, 5));
    endcase
  endfunction

  // Mostly a few stack slots; some with high bits that the STRB mask drops
  function automatic logic [15:0] pick_slot();
    case ($urandom_range(0, 9))
      0, 1:    return 16'($urandom);
      2:       return {7'($urandom), 9'($urandom_range(0, 7))};
      default: return 16'($urandom_range(0, 7));
    endcase
  endfunction

  // Offsets around the anchor, plus the full range
  function automatic logic [30:0] pick_offset();
    case ($urandom_range(0, 4))
      0:       return board.anchor;
      1:       return board.anchor + 31'd1;
      2:       return board.anchor - 31'd1;
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic instr_t random_instr();
    instr_t      it;
    int unsigned roll;
    it.rt     = pick_reg();
    it.rn     = ($urandom_range(0, 4) == 0) ? 5'($urandom) : SP_REG;
    it.rm     = pick_reg();
    it.imm    = pick_slot();
    it.offset = pick_offset();
    roll      = $urandom_range(0, 99);
    // Restart quickly once stopped so that most items reach the tracker
    if ((board.halted && roll < 40) || roll < 4)
      it.cmd = CMD_BEGIN;
    else if (roll < 6)
      it.cmd = CMD_FSTART;
    else if (roll < 9)
      it.cmd = CMD_OTHER;
    else if (roll < 11)
      it.cmd = cmd_t'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    else if (roll < 30)
      it.cmd = $urandom_range(0, 1) ? CMD_STRX : CMD_STRW;
    else if (roll < 50)
      it.cmd = $urandom_range(0, 1) ? CMD_LDRX : CMD_LDRW;
    else if (roll < 68)
      it.cmd = $urandom_range(0, 1) ? CMD_MOVX : CMD_MOVW;
    else
      case ($urandom_range(0, 2))
        0:       it.cmd = CMD_STRB_IMM;
        1:       it.cmd = CMD_STRB_POST;
        default: it.cmd = CMD_STRB_PRE;
      endcase
    return it;
  endfunction

  // Count only items that the tracker acts on
  task automatic run_random(input int unsigned target);
    int unsigned live;
    instr_t      it;
    live = 0;
    while (live < target) begin
      it = random_instr();
      if (it.cmd == CMD_BEGIN || !board.halted) live++;
      feed(it);
    end
  endtask

  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("forward_value_location_tracker_unit test failed");
    $finish;
  end

  initial begin
    int unsigned k;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_anchor(31'd100);
    // Stopped after reset: nothing moves, function start reports no boundary
    feed(decoded(CMD_STRB_IMM, 5'd0, SP_REG, 5'd0, 16'd0, 31'h7FFF_FFFF));
    feed(decoded(CMD_FSTART, 5'd0, 5'd0, 5'd0, 16'd0, 31'($urandom)));
    feed(decoded(CMD_MOVX, 5'd1, 5'd0, 5'd0, 16'd0, 31'($urandom)));
    // Begin, then begin again while tracking
    feed(decoded(CMD_BEGIN, 5'd0, 5'd0, 5'd0, 16'd0, 31'($urandom)));
    feed(decoded(CMD_BEGIN, SP_REG, 5'd0, 5'd0, 16'd0, 31'($urandom)));
    feed(decoded(CMD_MOVX, 5'd3, 5'd0, SP_REG, 16'd0, 31'($urandom)));
    feed(decoded(CMD_OTHER, 5'd3, SP_REG, 5'd3, 16'hFFFF, 31'($urandom)));
    feed(decoded(CMD_UNUSED_LO, 5'd3, SP_REG, 5'd3, 16'hFFFF, 31'($urandom)));
    feed(decoded(CMD_UNUSED_HI, 5'd3, SP_REG, 5'd3, 16'hFFFF, 31'($urandom)));
    // Spill, non-stack base, reload, overwrite of the slot and of the register
    feed(decoded(CMD_STRX, 5'd3, SP_REG, 5'd0, 16'hFFFF, 31'($urandom)));
    feed(decoded(CMD_STRX, 5'd3, 5'd0, 5'd0, 16'h0000, 31'($urandom)));
    feed(decoded(CMD_LDRX, 5'd7, SP_REG, 5'd0, 16'hFFFF, 31'($urandom)));
    feed(decoded(CMD_STRW, 5'd9, SP_REG, 5'd0, 16'hFFFF, 31'($urandom)));
    feed(decoded(CMD_LDRW, 5'd7, SP_REG, 5'd0, 16'h0000, 31'($urandom)));
    // Move into the stack pointer only overwrites it
    feed(decoded(CMD_MOVW, SP_REG, 5'd0, 5'd3, 16'd0, 31'($urandom)));
    // Byte stores: full immediate, masked post and pre, untracked overwrite
    feed(decoded(CMD_STRB_IMM, 5'd3, SP_REG, 5'd0, 16'hFFFF, 31'($urandom)));
    feed(decoded(CMD_STRB_POST, 5'd3, SP_REG, 5'd0, 16'hFFFF, 31'($urandom)));
    feed(decoded(CMD_STRB_PRE, 5'd3, SP_REG, 5'd0, 16'h0200, 31'($urandom)));
    feed(decoded(CMD_STRB_PRE, 5'd20, SP_REG, 5'd0, 16'hFFFF, 31'($urandom)));
    feed(decoded(CMD_STRB_IMM, 5'd3, 5'd5, 5'd0, 16'd4, 31'($urandom)));
    // Empty the set, then byte stores at and past the anchor
    feed(decoded(CMD_BEGIN, SP_REG, 5'd0, 5'd0, 16'd0, 31'($urandom)));
    feed(decoded(CMD_MOVX, SP_REG, 5'd0, SP_REG, 16'd0, 31'($urandom)));
    feed(decoded(CMD_STRB_IMM, 5'd1, SP_REG, 5'd0, 16'd8, 31'd100));
    feed(decoded(CMD_STRB_POST, 5'd1, 5'd0, 5'd0, 16'd8, 31'd101));
    feed(decoded(CMD_STRB_IMM, 5'd1, SP_REG, 5'd0, 16'd8, 31'h7FFF_FFFF));
    // Function start while tracking, then an ignored spill
    feed(decoded(CMD_FSTART, 5'd0, 5'd0, 5'd0, 16'd0, 31'($urandom)));
    feed(decoded(CMD_STRX, 5'd1, SP_REG, 5'd0, 16'd8, 31'($urandom)));

    write_anchor(31'h7FFF_FFFF);
    run_random(RANDOM_PER_PHASE);

    // Fill the set with spills of one register, then push past its capacity
    write_anchor('0);
    feed(decoded(CMD_BEGIN, 5'd0, SP_REG, 5'd0, 16'd0, 31'($urandom)));
    for (k = 1; k < MAX_LOC; k++)
      feed(decoded(CMD_STRX, 5'd0, SP_REG, 5'd0, 16'(k), 31'($urandom)));
    feed(decoded(CMD_STRX, 5'd0, SP_REG, 5'd0, 16'hFFFF, 31'($urandom)));
    feed(decoded(CMD_LDRX, 5'd1, SP_REG, 5'd0, 16'd1, 31'($urandom)));
    feed(decoded(CMD_MOVX, 5'd2, 5'd0, 5'd0, 16'd0, 31'($urandom)));
    feed(decoded(CMD_STRB_IMM, 5'd0, SP_REG, 5'd0, 16'd5, 31'($urandom)));
    feed(decoded(CMD_STRX, 5'd9, SP_REG, 5'd0, 16'd1, 31'($urandom)));
    feed(decoded(CMD_MOVX, 5'd2, 5'd0, 5'd0, 16'd0, 31'($urandom)));
    feed(decoded(CMD_MOVW, 5'd4, 5'd0, 5'd0, 16'd0, 31'($urandom)));
    feed(decoded(CMD_STRX, 5'd0, SP_REG, 5'd0, 16'd2, 31'($urandom)));
    feed(decoded(CMD_BEGIN, 5'd6, 5'd0, 5'd0, 16'd0, 31'($urandom)));
    run_random(RANDOM_PER_PHASE);

    write_anchor(31'($urandom));
    run_random(RANDOM_PER_PHASE);
    write_anchor(31'd1);
    run_random(RANDOM_PER_PHASE);
    write_anchor(31'($urandom));
    run_random(RANDOM_PER_PHASE);

    drain(TAIL_CYCLES);
    if (board.mismatches == 0 && board.expected_results.size() == 0)
      $display("forward_value_location_tracker_unit test passed");
    else
      $display("forward_value_location_tracker_unit test failed");
    $finish;
  end

endmodule

// ----- forward_value_location_tracker_unit.f -----
+incdir+src
src/fvlt_pkg.sv
src/fvlt_ram.sv
src/fvlt_decode.sv
src/forward_value_location_tracker_unit.sv
tb/sv/tb.sv
